[hdl/segment_rectangle_intersect_core_defines.svh]
// Assertion macros shared by the segment/rectangle intersect design.
`ifndef SEGMENT_RECTANGLE_INTERSECT_CORE_DEFINES_SVH
`define SEGMENT_RECTANGLE_INTERSECT_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SRI_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sri same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SRI_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sri next-cycle check failed");

`endif

[hdl/sri_pkg.sv]
// Types, widths and helpers for the segment/rectangle intersect pipeline.
package sri_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * COORD_WIDTH + 2;
   localparam int CROSS_WIDTH = 2 * COORD_WIDTH + 3;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [CROSS_WIDTH-1:0] cross_type;

   // Sign of a value: negative, zero, or (neither) positive.
   typedef struct packed {
      logic neg;
      logic zero;
   } sign_type;

   // Load strobes for the multiply and subtract stages of a corner unit.
   typedef struct packed {
      logic mul_en;
      logic sub_en;
   } stage_en_type;

   function automatic diff_type sub_coord(input coord_type a, input coord_type b);
      diff_type ea;
      diff_type eb;
      ea = {a[COORD_WIDTH-1], a};
      eb = {b[COORD_WIDTH-1], b};
      return ea - eb;
   endfunction

   // Sign of a - b without forming the difference.
   function automatic sign_type cmp_sign(input coord_type a, input coord_type b);
      sign_type s;
      s.neg  = (a < b);
      s.zero = (a == b);
      return s;
   endfunction

   // Strictly opposite signs, or both zero.
   function automatic logic straddle(input sign_type a, input sign_type b);
      logic a_pos;
      logic b_pos;
      a_pos = !a.neg && !a.zero;
      b_pos = !b.neg && !b.zero;
      return (a.neg && b_pos) || (a_pos && b.neg) || (a.zero && b.zero);
   endfunction

endpackage

[hdl/segment_rectangle_intersect_core.sv]
// Segment versus axis-aligned rectangle collision test, four-stage pipeline.
// Stages from request accept to rsp_valid: differences, products,
// cross-product signs, edge combine into the output register.
// Throughput: one request per cycle; each stage holds its item on a stall
// and empty stages fill while later ones wait.
// Reset: synchronous, active high; clears every stage valid bit.
module segment_rectangle_intersect_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sri_pkg::coord_type req_path_start_x,
   input  sri_pkg::coord_type req_path_start_y,
   input  sri_pkg::coord_type req_path_end_x,
   input  sri_pkg::coord_type req_path_end_y,
   input  sri_pkg::coord_type req_rect_left,
   input  sri_pkg::coord_type req_rect_right,
   input  sri_pkg::coord_type req_rect_low,
   input  sri_pkg::coord_type req_rect_high,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_hit
);

`include "segment_rectangle_intersect_core_defines.svh"

   // Corner order: left/low, right/low, left/high, right/high.
   // Edge order: bottom, top, right, left.
   localparam int NUM_CORNERS = 4;
   localparam int NUM_EDGES   = 4;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic ready1, ready2, ready3, ready4;
   sri_pkg::stage_en_type stage_en;

   // Stage 1 payload
   sri_pkg::diff_type dx_ff, dy_ff;
   sri_pkg::diff_type ex_l_ff, ex_r_ff, ey_lo_ff, ey_hi_ff;
   logic              box1_ff, box1_in;
   logic [NUM_EDGES-1:0] eb1_ff, eb1_in;
   // Carried flags for stages 2 and 3
   logic              box2_ff, box3_ff;
   logic [NUM_EDGES-1:0] eb2_ff, eb3_ff;
   // Output
   logic              hit_ff, hit_in;

   sri_pkg::sign_type corner_sign [NUM_CORNERS];
   sri_pkg::diff_type corner_ex   [NUM_CORNERS];
   sri_pkg::diff_type corner_ey   [NUM_CORNERS];
   logic [NUM_EDGES-1:0] ea;

   assign ready4    = !v4_ff || rsp_ready;
   assign ready3    = !v3_ff || ready4;
   assign ready2    = !v2_ff || ready3;
   assign ready1    = !v1_ff || ready2;
   assign req_ready = ready1;

   assign stage_en.mul_en = ready2 && v1_ff;
   assign stage_en.sub_en = ready3 && v2_ff;

   // Box test and the straddle of each edge's line by the path endpoints.
   always_comb begin
      logic pminx_hi;
      logic pminy_hi;
      sri_pkg::coord_type pminx, pmaxx, pminy, pmaxy;
      pminx_hi = (req_path_start_x > req_path_end_x);
      pminy_hi = (req_path_start_y > req_path_end_y);
      pminx = pminx_hi ? req_path_end_x : req_path_start_x;
      pmaxx = pminx_hi ? req_path_start_x : req_path_end_x;
      pminy = pminy_hi ? req_path_end_y : req_path_start_y;
      pmaxy = pminy_hi ? req_path_start_y : req_path_end_y;
      box1_in = (pmaxx >= req_rect_left) && (req_rect_right >= pminx) &&
                (pmaxy >= req_rect_low) && (req_rect_high >= pminy);
      // Horizontal edges: a zero-length edge is straddled by anything.
      eb1_in[0] = (req_rect_right == req_rect_left) ||
                  sri_pkg::straddle(sri_pkg::cmp_sign(req_path_start_y, req_rect_low),
                                    sri_pkg::cmp_sign(req_path_end_y, req_rect_low));
      eb1_in[1] = (req_rect_right == req_rect_left) ||
                  sri_pkg::straddle(sri_pkg::cmp_sign(req_path_start_y, req_rect_high),
                                    sri_pkg::cmp_sign(req_path_end_y, req_rect_high));
      // Vertical edges
      eb1_in[2] = (req_rect_high == req_rect_low) ||
                  sri_pkg::straddle(sri_pkg::cmp_sign(req_path_start_x, req_rect_right),
                                    sri_pkg::cmp_sign(req_path_end_x, req_rect_right));
      eb1_in[3] = (req_rect_high == req_rect_low) ||
                  sri_pkg::straddle(sri_pkg::cmp_sign(req_path_start_x, req_rect_left),
                                    sri_pkg::cmp_sign(req_path_end_x, req_rect_left));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= req_valid;
         if (ready2) v2_ff <= v1_ff;
         if (ready3) v3_ff <= v2_ff;
         if (ready4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && req_valid) begin
         dx_ff    <= sri_pkg::sub_coord(req_path_end_x, req_path_start_x);
         dy_ff    <= sri_pkg::sub_coord(req_path_end_y, req_path_start_y);
         ex_l_ff  <= sri_pkg::sub_coord(req_rect_left, req_path_start_x);
         ex_r_ff  <= sri_pkg::sub_coord(req_rect_right, req_path_start_x);
         ey_lo_ff <= sri_pkg::sub_coord(req_rect_low, req_path_start_y);
         ey_hi_ff <= sri_pkg::sub_coord(req_rect_high, req_path_start_y);
         box1_ff  <= box1_in;
         eb1_ff   <= eb1_in;
      end
      if (stage_en.mul_en) begin
         box2_ff <= box1_ff;
         eb2_ff  <= eb1_ff;
      end
      if (stage_en.sub_en) begin
         box3_ff <= box2_ff;
         eb3_ff  <= eb2_ff;
      end
      if (ready4 && v3_ff) begin
         hit_ff <= hit_in;
      end
   end

   assign corner_ex[0] = ex_l_ff;
   assign corner_ey[0] = ey_lo_ff;
   assign corner_ex[1] = ex_r_ff;
   assign corner_ey[1] = ey_lo_ff;
   assign corner_ex[2] = ex_l_ff;
   assign corner_ey[2] = ey_hi_ff;
   assign corner_ex[3] = ex_r_ff;
   assign corner_ey[3] = ey_hi_ff;

   for (genvar c = 0; c < NUM_CORNERS; c++) begin : g_corner
      sri_corner_cross u_cross (
         .clock      (clock),
         .stage_en   (stage_en),
         .corner_dx  (corner_ex[c]),
         .corner_dy  (corner_ey[c]),
         .path_dx    (dx_ff),
         .path_dy    (dy_ff),
         .cross_sign (corner_sign[c])
      );
   end

   // Path line straddled by each edge's two corners.
   always_comb begin
      ea[0]  = sri_pkg::straddle(corner_sign[0], corner_sign[1]);
      ea[1]  = sri_pkg::straddle(corner_sign[2], corner_sign[3]);
      ea[2]  = sri_pkg::straddle(corner_sign[1], corner_sign[3]);
      ea[3]  = sri_pkg::straddle(corner_sign[0], corner_sign[2]);
      hit_in = box3_ff && (|(ea & eb3_ff));
   end

   assign rsp_valid = v4_ff;
   assign rsp_hit   = hit_ff;

   `SRI_ASSERT_NXT(a_no_hit_outside_box, v3_ff && ready4 && !box3_ff, !rsp_hit)
   `SRI_ASSERT_NXT(a_stage3_held, v3_ff && !ready4, v3_ff)
   `SRI_ASSERT_IMP(a_full_blocks_req, v1_ff && v2_ff && v3_ff && v4_ff && !rsp_ready,
                   !req_ready)

endmodule

[hdl/sri_corner_cross.sv]
// Two-stage cross product of one rectangle corner against the path line.
module sri_corner_cross (
   input  logic                   clock,
   input  sri_pkg::stage_en_type  stage_en,
   input  sri_pkg::diff_type      corner_dx,
   input  sri_pkg::diff_type      corner_dy,
   input  sri_pkg::diff_type      path_dx,
   input  sri_pkg::diff_type      path_dy,
   output sri_pkg::sign_type      cross_sign
);

   sri_pkg::prod_type  prod_a_ff, prod_a_in;
   sri_pkg::prod_type  prod_b_ff, prod_b_in;
   sri_pkg::cross_type cross_in;
   sri_pkg::sign_type  sign_ff, sign_in;

   assign prod_a_in = sri_pkg::prod_type'(corner_dx) * sri_pkg::prod_type'(path_dy);
   assign prod_b_in = sri_pkg::prod_type'(corner_dy) * sri_pkg::prod_type'(path_dx);

   always_comb begin
      cross_in     = sri_pkg::cross_type'(prod_a_ff) - sri_pkg::cross_type'(prod_b_ff);
      sign_in.neg  = cross_in[sri_pkg::CROSS_WIDTH-1];
      sign_in.zero = (cross_in == '0);
   end

   always_ff @(posedge clock) begin
      if (stage_en.mul_en) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
      end
      if (stage_en.sub_en) begin
         sign_ff <= sign_in;
      end
   end

   assign cross_sign = sign_ff;

endmodule
